FILE: design/xre_pkg.sv
// xre_pkg: shared types and constants of the xmodem receive engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package xre_pkg;

	// link control characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_C   = 8'h43;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// frame sizes count the payload plus number, complement and two crc bytes, not the header
	localparam int FRAME_SHORT = 132;
	localparam int FRAME_LONG  = 1028;
	localparam int POS_W       = 11;
	localparam logic [POS_W-1:0] PAYLOAD_SHORT = POS_W'(FRAME_SHORT - 4);
	localparam logic [POS_W-1:0] PAYLOAD_LONG  = POS_W'(FRAME_LONG - 4);
	localparam logic [8:0] CMPL_SUM = 9'd255;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [1:0] {
		KIND_NAME    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_REPLY   = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		VERD_NONE   = 2'd0,
		VERD_COMMIT = 2'd1,
		VERD_DUP    = 2'd2,
		VERD_CRC    = 2'd3
	} verdict_t;

	localparam logic [2:0] ST_RUNNING   = 3'd0;
	localparam logic [2:0] ST_COMPLETE  = 3'd1;
	localparam logic [2:0] ST_BAD_HDR   = 3'd2;
	localparam logic [2:0] ST_BAD_CMPL  = 3'd3;
	localparam logic [2:0] ST_SEQ_ERR   = 3'd4;
	localparam logic [2:0] ST_NAME_LONG = 3'd5;

	typedef enum logic [2:0] {
		PH_NAME    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_NUMBER  = 3'd2,
		PH_COMPL   = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRC_HI  = 3'd5,
		PH_CRC_LO  = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       new_session;
	} in_word_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic [1:0] block_verdict;
		logic [2:0] end_status;
	} out_word_t;

endpackage

`default_nettype wire

FILE: design/xre_crc.sv
// xre_crc: one-byte update of crc-16/xmodem (poly 0x1021, msb first)
// depends on xre_pkg for the polynomial
`timescale 1ns / 1ps
`default_nettype none

module xre_crc
	import xre_pkg::*;
(
	input  wire logic [15:0] crc,
	input  wire logic [7:0]  data,
	output logic [15:0]      crc_next
);

	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

`default_nettype wire

FILE: design/xre_parser.sv
// xre_parser: session phase machine, frame registers and frame-end checks
// depends on xre_pkg and xre_crc
`timescale 1ns / 1ps
`default_nettype none

module xre_parser
	import xre_pkg::*;
#(
	parameter int NAME_MAX = 19
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_word_t word,
	output logic          emit,
	output out_word_t     res
);

	localparam int NL_W = $clog2(NAME_MAX + 1);
	localparam logic [NL_W-1:0] NAME_LIMIT = NL_W'(NAME_MAX);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q;
	logic             long_q;
	logic [7:0]       num_q;
	logic [7:0]       cmpl_q;
	logic [15:0]      crc_q;
	logic [7:0]       crc_hi_q;
	logic [7:0]       last_good_q;
	logic [NL_W-1:0]  name_len_q;

	logic [15:0]      crc_next;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] payload_len;
	logic [7:0]       b;
	logic             name_full, cmpl_bad, dup, crc_bad, seq_bad;

	xre_crc u_crc (
		.crc      (crc_q),
		.data     (word.rx_byte),
		.crc_next (crc_next)
	);

	assign b           = word.rx_byte;
	assign pos_next    = pos_q + POS_W'(1);
	assign payload_len = long_q ? PAYLOAD_LONG : PAYLOAD_SHORT;
	assign name_full   = name_len_q >= NAME_LIMIT;
	assign cmpl_bad    = ({1'b0, num_q} + {1'b0, cmpl_q}) != CMPL_SUM;
	assign dup         = num_q == last_good_q;
	assign crc_bad     = (crc_hi_q != crc_q[15:8]) || (b != crc_q[7:0]);
	assign seq_bad     = num_q != (last_good_q + 8'd1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_NAME: begin
				if (b == CH_CR) phase_d = PH_HEADER;
				else if (name_full) phase_d = PH_DONE;
			end
			PH_HEADER: begin
				if (b == CH_SOH || b == CH_STX) phase_d = PH_NUMBER;
				else phase_d = PH_DONE;
			end
			PH_NUMBER:  phase_d = PH_COMPL;
			PH_COMPL:   phase_d = PH_PAYLOAD;
			PH_PAYLOAD: begin
				if (pos_next >= payload_len) phase_d = PH_CRC_HI;
			end
			PH_CRC_HI:  phase_d = PH_CRC_LO;
			PH_CRC_LO: begin
				if (cmpl_bad) phase_d = PH_DONE;
				else if (dup || crc_bad) phase_d = PH_HEADER;
				else if (seq_bad) phase_d = PH_DONE;
				else phase_d = PH_HEADER;
			end
			PH_DONE:    phase_d = PH_DONE;
			default:    phase_d = PH_DONE;
		endcase
		if (word.new_session) phase_d = PH_NAME;
	end

	// result word
	always_comb begin
		emit = 1'b0;
		res  = '{out_kind: KIND_REPLY, out_byte: 8'h00,
			block_verdict: VERD_NONE, end_status: ST_RUNNING};
		case (phase_q)
			PH_NAME: begin
				emit = 1'b1;
				if (b == CH_CR) begin
					res.out_byte = CH_C;
				end else if (name_full) begin
					res.out_kind   = KIND_END;
					res.end_status = ST_NAME_LONG;
				end else begin
					res.out_kind = KIND_NAME;
					res.out_byte = b;
				end
			end
			PH_HEADER: begin
				if (b == CH_EOT) begin
					emit           = 1'b1;
					res.out_byte   = CH_ACK;
					res.end_status = ST_COMPLETE;
				end else if (b != CH_SOH && b != CH_STX) begin
					emit           = 1'b1;
					res.out_kind   = KIND_END;
					res.end_status = ST_BAD_HDR;
				end
			end
			PH_PAYLOAD: begin
				emit         = 1'b1;
				res.out_kind = KIND_PAYLOAD;
				res.out_byte = b;
			end
			PH_CRC_LO: begin
				emit = 1'b1;
				if (cmpl_bad) begin
					res.out_kind   = KIND_END;
					res.end_status = ST_BAD_CMPL;
				end else if (dup) begin
					res.out_byte      = CH_ACK;
					res.block_verdict = VERD_DUP;
				end else if (crc_bad) begin
					res.out_byte      = CH_NAK;
					res.block_verdict = VERD_CRC;
				end else if (seq_bad) begin
					res.out_kind   = KIND_END;
					res.end_status = ST_SEQ_ERR;
				end else begin
					res.out_byte      = CH_ACK;
					res.block_verdict = VERD_COMMIT;
				end
			end
			default: emit = 1'b0;
		endcase
		if (word.new_session) emit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NAME;
			pos_q       <= '0;
			long_q      <= 1'b0;
			num_q       <= '0;
			cmpl_q      <= '0;
			crc_q       <= '0;
			crc_hi_q    <= '0;
			last_good_q <= '0;
			name_len_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (word.new_session) begin
				pos_q       <= '0;
				long_q      <= 1'b0;
				num_q       <= '0;
				cmpl_q      <= '0;
				crc_q       <= '0;
				crc_hi_q    <= '0;
				last_good_q <= '0;
				name_len_q  <= '0;
			end else begin
				case (phase_q)
					PH_NAME: begin
						if (b != CH_CR && !name_full) name_len_q <= name_len_q + NL_W'(1);
					end
					PH_HEADER: begin
						if (b == CH_SOH || b == CH_STX) begin
							long_q <= (b == CH_STX);
							pos_q  <= '0;
							crc_q  <= '0;
						end
					end
					PH_NUMBER:  num_q <= b;
					PH_COMPL:   cmpl_q <= b;
					PH_PAYLOAD: begin
						crc_q <= crc_next;
						pos_q <= pos_next;
					end
					PH_CRC_HI:  crc_hi_q <= b;
					PH_CRC_LO: begin
						if (!cmpl_bad && !dup && !crc_bad && !seq_bad) last_good_q <= num_q;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/xmodem_receive_engine.sv
// xmodem_receive_engine: top level with input stage and result register
// depends on xre_pkg and xre_parser
`timescale 1ns / 1ps
`default_nettype none

// Receiver for an XMODEM-CRC / XMODEM-1K session, one link byte per word. A
// word is taken into an input register and processed by the phase machine
// once the result register is free; the machine updates the CRC and frame
// state and loads the result register. One word per cycle is sustained while
// result_stall is low. While a result waits under stall, one more word can
// be taken into the input register. A word with new_session set clears all
// session state and gives no result. Bytes after the session ends give no result.
module xmodem_receive_engine
	import xre_pkg::*;
#(
	parameter int NAME_MAX = 19
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_stall,
	input  wire in_word_t item,
	output logic          result_valid,
	input  wire logic     result_stall,
	output out_word_t     result
);

	logic      valid_s1;
	in_word_t  item_s1;
	logic      result_valid_q;
	out_word_t result_q;
	logic      out_ready, step, emit;
	out_word_t res;

	assign out_ready    = !result_valid_q || !result_stall;
	assign step         = valid_s1 && out_ready;
	assign item_stall   = valid_s1 && !out_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	xre_parser #(
		.NAME_MAX (NAME_MAX)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.word   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_ready) begin
			result_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) result_q <= res;
	end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for the xmodem receive engine
// depends on xre_pkg and xmodem_receive_engine; predicts every result word in a scoreboard
`timescale 1ns / 1ps

module tb_top;
	import xre_pkg::*;

	localparam int NAME_LIMIT = 19;

	class xre_scoreboard;
		out_word_t   due_words[$];
		int          mismatches;
		int          name_max;
		phase_t      phase;
		logic [10:0] position;
		logic        wide;
		logic [7:0]  number;
		logic [7:0]  complement;
		logic [7:0]  crc_high;
		logic [7:0]  last_good;
		logic [15:0] crc;
		int          name_len;

		function new(int limit);
			name_max = limit;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			phase = PH_NAME;
			position = '0;
			wide = 1'b0;
			number = '0;
			complement = '0;
			crc_high = '0;
			last_good = '0;
			crc = '0;
			name_len = 0;
		endfunction

		static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic [15:0] x;
			x = c ^ {b, 8'h00};
			for (int i = 0; i < 8; i++)
				x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
			return x;
		endfunction

		function void note_input(in_word_t w);
			out_word_t  r;
			bit         emit;
			logic [7:0] b;
			b = w.rx_byte;
			r = '0;
			emit = 1'b1;
			if (w.new_session) begin
				restart();
				return;
			end
			case (phase)
			PH_NAME: begin
				if (b == CH_CR) begin
					phase = PH_HEADER;
					r.out_kind = KIND_REPLY;
					r.out_byte = CH_C;
				end else if (name_len >= name_max) begin
					phase = PH_DONE;
					r.out_kind = KIND_END;
					r.end_status = ST_NAME_LONG;
				end else begin
					name_len++;
					r.out_kind = KIND_NAME;
					r.out_byte = b;
				end
			end
			PH_HEADER: begin
				if (b == CH_EOT) begin
					phase = PH_DONE;
					r.out_kind = KIND_REPLY;
					r.out_byte = CH_ACK;
					r.end_status = ST_COMPLETE;
				end else if (b == CH_SOH || b == CH_STX) begin
					wide = (b == CH_STX);
					position = '0;
					crc = '0;
					phase = PH_NUMBER;
					emit = 1'b0;
				end else begin
					phase = PH_DONE;
					r.out_kind = KIND_END;
					r.end_status = ST_BAD_HDR;
				end
			end
			PH_NUMBER: begin
				number = b;
				phase = PH_COMPL;
				emit = 1'b0;
			end
			PH_COMPL: begin
				complement = b;
				phase = PH_PAYLOAD;
				emit = 1'b0;
			end
			PH_PAYLOAD: begin
				crc = crc_step(crc, b);
				position = position + 11'd1;
				if (position >= (wide ? PAYLOAD_LONG : PAYLOAD_SHORT))
					phase = PH_CRC_HI;
				r.out_kind = KIND_PAYLOAD;
				r.out_byte = b;
			end
			PH_CRC_HI: begin
				crc_high = b;
				phase = PH_CRC_LO;
				emit = 1'b0;
			end
			PH_CRC_LO: begin
				// checks run in a fixed order: complement, duplicate, crc, sequence
				if ((9'(number) + 9'(complement)) != CMPL_SUM) begin
					phase = PH_DONE;
					r.out_kind = KIND_END;
					r.end_status = ST_BAD_CMPL;
				end else if (number == last_good) begin
					phase = PH_HEADER;
					r.out_kind = KIND_REPLY;
					r.out_byte = CH_ACK;
					r.block_verdict = VERD_DUP;
				end else if ({crc_high, b} != crc) begin
					phase = PH_HEADER;
					r.out_kind = KIND_REPLY;
					r.out_byte = CH_NAK;
					r.block_verdict = VERD_CRC;
				end else if (number != last_good + 8'd1) begin
					phase = PH_DONE;
					r.out_kind = KIND_END;
					r.end_status = ST_SEQ_ERR;
				end else begin
					last_good = number;
					phase = PH_HEADER;
					r.out_kind = KIND_REPLY;
					r.out_byte = CH_ACK;
					r.block_verdict = VERD_COMMIT;
				end
			end
			default: emit = 1'b0;
			endcase
			if (emit)
				due_words.push_back(r);
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d byte %02h verdict %0d status %0d",
						got.out_kind, got.out_byte, got.block_verdict, got.end_status);
				return;
			end
			want = due_words.pop_front();
			if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
				got.block_verdict !== want.block_verdict ||
				got.end_status !== want.end_status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected kind %0d byte %02h verdict %0d status %0d, %s",
						want.out_kind, want.out_byte, want.block_verdict, want.end_status,
						$sformatf("got kind %0d byte %02h verdict %0d status %0d",
							got.out_kind, got.out_byte, got.block_verdict, got.end_status));
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	in_word_t  item = '0;
	logic      item_stall;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result;

	xre_scoreboard sb;
	bit            calm = 1'b0;
	int            words_sent = 0;

	xmodem_receive_engine #(
		.NAME_MAX(NAME_LIMIT)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [7:0] name_char();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_CR);
		return b;
	endfunction

	function automatic logic [7:0] bad_header();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_SOH || b == CH_STX || b == CH_EOT);
		return b;
	endfunction

	always @(posedge clk) begin
		if (item_valid && !item_stall)
			sb.note_input(item);
		if (result_valid && !result_stall)
			sb.check_result(result);
	end

	initial begin
		int hold;
		@(posedge clk);
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	task automatic put_word(input logic [7:0] b, input bit restart);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= '{rx_byte: b, new_session: restart};
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic put_stray();
		repeat ($urandom_range(0, 3))
			put_word(8'($urandom), 1'b0);
	endtask

	// hold the sender until every predicted word has come back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_words.size() != 0)
			@(posedge clk);
	endtask

	// one session: name, frames, then mostly an end; steady keeps the session alive until
	// the block number has wrapped past 255
	task automatic run_session(input int frames, input bit steady, input bit wide_first);
		logic [7:0]  last_num;
		logic [7:0]  num;
		logic [7:0]  cmpl;
		logic [7:0]  b;
		logic [15:0] sum;
		int          pick;
		int          goods;
		int          name_len;
		bit          wide;
		last_num = '0;
		goods = 0;
		put_word(8'($urandom), 1'b1);
		pick = $urandom_range(0, 19);
		if (pick == 0 && !steady) begin
			repeat (NAME_LIMIT + 1) put_word(name_char(), 1'b0);
			put_stray();
			return;
		end
		name_len = (pick < 4) ? NAME_LIMIT : $urandom_range(0, 6);
		repeat (name_len) put_word(name_char(), 1'b0);
		put_word(CH_CR, 1'b0);
		for (int f = 0; steady ? (goods < 258) : (f < frames); f++) begin
			wide = !steady && ((wide_first && f == 0) || $urandom_range(0, 39) == 0);
			pick = steady ? $urandom_range(0, 85) : $urandom_range(0, 99);
			// long frames are cut short by a restart
			if (wide)
				pick = $urandom_range(94, 96);
			num = last_num + 8'd1;
			if (pick >= 70 && pick < 78)
				num = last_num;
			if (pick >= 90 && pick < 94)
				num = last_num + 8'($urandom_range(2, 255));
			cmpl = ~num;
			if (pick >= 86 && pick < 90)
				cmpl = cmpl ^ 8'($urandom_range(1, 255));
			if (pick >= 97) begin
				put_word(bad_header(), 1'b0);
				put_stray();
				return;
			end
			put_word(wide ? CH_STX : CH_SOH, 1'b0);
			put_word(num, 1'b0);
			put_word(cmpl, 1'b0);
			if (pick >= 94) begin
				// restart in the middle of a frame
				repeat ($urandom_range(0, 20)) put_word(8'($urandom), 1'b0);
				put_word(8'($urandom), 1'b1);
				return;
			end
			sum = '0;
			for (int i = 0; i < int'(wide ? PAYLOAD_LONG : PAYLOAD_SHORT); i++) begin
				b = 8'($urandom);
				sum = xre_scoreboard::crc_step(sum, b);
				put_word(b, 1'b0);
			end
			if (pick >= 78 && pick < 86)
				sum = sum ^ (16'd1 << $urandom_range(0, 15));
			put_word(sum[15:8], 1'b0);
			put_word(sum[7:0], 1'b0);
			if (pick >= 86) begin
				put_stray();
				return;
			end
			if (pick < 70) begin
				last_num = num;
				goods++;
			end
		end
		pick = $urandom_range(0, 9);
		if (pick < 8)
			put_word(CH_EOT, 1'b0);
		else if (pick == 8)
			put_word(bad_header(), 1'b0);
		put_stray();
	endtask

	initial begin
		int base;
		int left;
		sb = new(NAME_LIMIT);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// name extremes, bad header, bytes after the end
		put_word(8'hFF, 1'b1);
		put_word(8'h00, 1'b0);
		put_word(8'hFF, 1'b0);
		put_word(CH_CR, 1'b0);
		put_word(8'h03, 1'b0);
		put_word(CH_EOT, 1'b0);
		// empty name, then eot
		put_word(8'h00, 1'b1);
		put_word(CH_CR, 1'b0);
		put_word(CH_EOT, 1'b0);
		put_word(8'hFF, 1'b0);
		// restart in the middle of a long frame
		put_word(8'h5A, 1'b1);
		put_word(CH_CR, 1'b0);
		put_word(CH_STX, 1'b0);
		put_word(8'hFF, 1'b0);
		put_word(8'h00, 1'b0);
		put_word(8'hAB, 1'b0);
		put_word(8'hA5, 1'b1);
		put_word(CH_CR, 1'b0);
		put_word(8'h00, 1'b0);

		base = words_sent;
		while (words_sent - base < 600) begin
			calm = ($urandom_range(0, 4) == 0);
			left = 600 - (words_sent - base);
			run_session($urandom_range(0, (left >= 560) ? 4 : left / 140), 1'b0, 1'b0);
			if ($urandom_range(0, 3) == 0)
				drain();
		end
		calm = 1'b0;
		drain();

		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.due_words.size() != 0)
			$display("%0d expected words never arrived", sb.due_words.size());
		if (sb.mismatches == 0 && sb.due_words.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
